[design/validated_fnv1a_pair_id_defines.svh]
// assertion macros for the validated fnv-1a pair id block
`ifndef VALIDATED_FNV1A_PAIR_ID_DEFINES_SVH
`define VALIDATED_FNV1A_PAIR_ID_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define FPI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpi assertion failed");
// next-cycle implication
`define FPI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpi assertion failed");
`else
`define FPI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FPI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[design/fpi_pkg.sv]
// shared types, constants and hash helpers for the pair id block
package fpi_pkg;

    localparam int unsigned HASH_W = 64;
    localparam int unsigned ID_W   = 63;
    localparam int unsigned LEN_W  = 16;

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    // prime is 2^40 + 0x1b3, only the low part needs a multiplier
    localparam logic [63:0] FNV_PRIME_LO = 64'h00000000000001B3;
    localparam int unsigned FNV_PRIME_SHIFT = 40;
    localparam logic [63:0] HASH_MASK = 64'h3FFFFFFFFFFFFFFF;
    localparam logic [63:0] NS_BIT    = 64'h4000000000000000;

    // domain tag, first character in the top byte
    localparam int unsigned DOMAIN_LEN = 13;
    localparam logic [DOMAIN_LEN*8-1:0] DOMAIN_TAG = "sd.content.v1";

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // controller to datapath
    typedef struct packed {
        logic       ready;
        logic       accept;
        logic       round;
        logic       use_len;
        logic [1:0] len_idx;
        logic       load;
    } fpi_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic opens;
        logic has_char;
        logic emit;
        logic out_busy;
    } fpi_status_t;

    // one fnv-1a round
    function automatic logic [63:0] fnv_round(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << FNV_PRIME_SHIFT) + (x * FNV_PRIME_LO);
    endfunction

    // hash after the domain tag, evaluated at elaboration
    function automatic logic [63:0] fnv_init();
        logic [63:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < DOMAIN_LEN; i++)
        begin
            h = fnv_round(h, DOMAIN_TAG[DOMAIN_LEN*8-1-8*i -: 8]);
        end
        return h;
    endfunction

    localparam logic [63:0] HASH_INIT = fnv_init();

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_DOT) || (c == CH_UNDER) || (c == CH_DASH);
    endfunction

    function automatic logic is_allowed(input logic [7:0] c);
        return ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
               ((c >= CH_ZERO) && (c <= CH_NINE)) || is_sep(c);
    endfunction

endpackage

[design/fpi_ctrl.sv]
// controller: sequences length rounds, character round and result load
module fpi_ctrl
    import fpi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  fpi_status_t status,
    output fpi_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LEN  = 2'd1;
    localparam logic [1:0] ST_CHAR = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       has_char_reg, has_char_next;
    logic       emit_reg, emit_next;

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        has_char_next = has_char_reg;
        emit_next     = emit_reg;
        cmd           = '0;
        cmd.len_idx   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept    = 1'b1;
                    has_char_next = status.has_char;
                    emit_next     = status.emit;
                    cnt_next      = 2'd0;
                    if (status.opens)
                        state_next = ST_LEN;
                    else if (status.has_char)
                        state_next = ST_CHAR;
                    else if (status.emit)
                        state_next = ST_EMIT;
                end
            end
            ST_LEN:
            begin
                cmd.round   = 1'b1;
                cmd.use_len = 1'b1;
                cnt_next    = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    if (has_char_reg)
                        state_next = ST_CHAR;
                    else if (emit_reg)
                        state_next = ST_EMIT;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_CHAR:
            begin
                cmd.round  = 1'b1;
                state_next = emit_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= 2'd0;
            has_char_reg <= 1'b0;
            emit_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            has_char_reg <= has_char_next;
            emit_reg     <= emit_next;
        end
    end

endmodule

[design/fpi_datapath.sv]
// datapath: running hash, text validation state and output register
module fpi_datapath
    import fpi_pkg::*;
#(
    parameter int unsigned MAX_ID_LEN = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  fpi_cmd_t          cmd,
    input  logic [7:0]        char_byte,
    input  logic              which_text,
    input  logic [LEN_W-1:0]  text_length,
    input  logic              first_of_text,
    input  logic              last_of_text,
    input  logic              out_ready,
    output fpi_status_t       status,
    output logic              out_valid,
    output logic [ID_W-1:0]   pair_id,
    output logic              id_valid
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ID_LEN);

    logic [HASH_W-1:0] hash_reg, hash_next;
    logic              ok_reg, ok_next;
    logic [LEN_W-1:0]  bytes_reg, bytes_next;
    logic              phase_reg, phase_next;
    logic              in_text_reg, in_text_next;
    logic              ok_hold_reg;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        char_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic              out_ok_reg;

    logic              opens, ends, len_zero, emit;
    logic [LEN_W-1:0]  base_cnt, inc_cnt, new_cnt;
    logic              ok_item;
    logic [7:0]        round_byte;

    // classify the offered item against the current text state
    always_comb
    begin
        opens    = first_of_text || !in_text_reg;
        len_zero = (text_length == '0);
        ends     = last_of_text || len_zero;
        emit     = ends && which_text;
        base_cnt = opens ? '0 : bytes_reg;
        inc_cnt  = (base_cnt != '1) ? base_cnt + LEN_W'(1) : base_cnt;
        new_cnt  = len_zero ? base_cnt : inc_cnt;
    end

    // validation of one item
    always_comb
    begin
        ok_item = 1'b1;
        if (!first_of_text && !in_text_reg)
            ok_item = 1'b0;
        if (first_of_text && in_text_reg)
            ok_item = 1'b0;
        if (opens && ((which_text != phase_reg) || len_zero || (text_length > MAX_LEN)))
            ok_item = 1'b0;
        if (len_zero)
            ok_item = 1'b0;
        else
        begin
            if (!is_allowed(char_byte))
                ok_item = 1'b0;
            if (opens && is_sep(char_byte))
                ok_item = 1'b0;
            if (base_cnt >= text_length)
                ok_item = 1'b0;
            if (last_of_text && (is_sep(char_byte) || (new_cnt != text_length)))
                ok_item = 1'b0;
        end
    end

    assign status.opens    = opens;
    assign status.has_char = !len_zero;
    assign status.emit     = emit;
    assign status.out_busy = out_valid_reg && !out_ready;

    // byte fed to the round unit: length little-endian, then the character
    always_comb
    begin
        unique case ({cmd.use_len, cmd.len_idx})
            3'b100:  round_byte = len_reg[7:0];
            3'b101:  round_byte = len_reg[15:8];
            3'b110:  round_byte = 8'd0;
            3'b111:  round_byte = 8'd0;
            default: round_byte = char_reg;
        endcase
    end

    // next state of the text tracking and hash
    always_comb
    begin
        hash_next      = hash_reg;
        ok_next        = ok_reg;
        bytes_next     = bytes_reg;
        phase_next     = phase_reg;
        in_text_next   = in_text_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.round)
            hash_next = fnv_round(hash_reg, round_byte);
        if (cmd.load)
        begin
            hash_next      = HASH_INIT;
            out_valid_next = 1'b1;
        end
        if (cmd.accept)
        begin
            if (emit)
            begin
                ok_next      = 1'b1;
                bytes_next   = '0;
                phase_next   = 1'b0;
                in_text_next = 1'b0;
            end
            else
            begin
                ok_next      = ok_reg && ok_item;
                bytes_next   = new_cnt;
                in_text_next = !ends;
                if (ends)
                    phase_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= HASH_INIT;
            ok_reg        <= 1'b1;
            bytes_reg     <= '0;
            phase_reg     <= 1'b0;
            in_text_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hash_reg      <= hash_next;
            ok_reg        <= ok_next;
            bytes_reg     <= bytes_next;
            phase_reg     <= phase_next;
            in_text_reg   <= in_text_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            char_reg    <= char_byte;
            len_reg     <= text_length;
            ok_hold_reg <= ok_reg && ok_item;
        end
        if (cmd.load)
        begin
            out_ok_reg <= ok_hold_reg;
            out_id_reg <= ok_hold_reg ? ID_W'((hash_reg & HASH_MASK) | NS_BIT) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign pair_id   = out_id_reg;
    assign id_valid  = out_ok_reg;

endmodule

[design/validated_fnv1a_pair_id.sv]
// Pair id hasher: takes the module text then the content key text, one character per
// transfer, and returns one 63-bit id when the second text ends. The hash is FNV-1a 64
// seeded with the "sd.content.v1" domain tag; each text contributes its 32-bit length
// (little-endian) then its characters. Invalid texts give id 0 with id_valid low. A
// transfer that opens a text is accepted, then takes four length rounds and a character
// round; other transfers take an accept and a character round; a zero-length transfer
// skips the character round. A transfer that ends the second text then loads the
// output register, waiting while the previous id there is not yet taken. These
// steps are set by the single hash round unit, which folds in one byte per cycle. The
// result waits in an output register, so the next text can start while it is held.
// No clearing pass after reset.
`include "validated_fnv1a_pair_id_defines.svh"

module validated_fnv1a_pair_id
    import fpi_pkg::*;
#(
    parameter int unsigned MAX_ID_LEN = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // char_byte[7:0], text_length[23:8]
    input  logic [1:0]  s_axis_tuser,   // which_text[0], first_of_text[1]
    input  logic        s_axis_tlast,   // last_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // pair_id[62:0], zero[63]
    output logic        m_axis_tuser    // id_valid
);

    fpi_cmd_t        cmd;
    fpi_status_t     status;
    logic [ID_W-1:0] pair_id;
    logic            id_valid;
    logic            in_xfer;
    logic            out_good;
    logic            out_bad;

    // sequencing
    fpi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    // hash and validation
    fpi_datapath #(
        .MAX_ID_LEN (MAX_ID_LEN)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .char_byte     (s_axis_tdata[7:0]),
        .which_text    (s_axis_tuser[0]),
        .text_length   (s_axis_tdata[23:8]),
        .first_of_text (s_axis_tuser[1]),
        .last_of_text  (s_axis_tlast),
        .out_ready     (m_axis_tready),
        .status        (status),
        .out_valid     (m_axis_tvalid),
        .pair_id       (pair_id),
        .id_valid      (id_valid)
    );

    assign s_axis_tready = cmd.ready;
    assign m_axis_tdata  = {1'b0, pair_id};
    assign m_axis_tuser  = id_valid;

    // terms for the checks below
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_good = m_axis_tvalid && m_axis_tuser;
    assign out_bad  = m_axis_tvalid && !m_axis_tuser;

    // an invalid result carries a zero id
    `FPI_ASSERT_IMP(a_invalid_zero, clk, rst_n, out_bad, m_axis_tdata == 64'd0)
    // a valid result has the namespace bit set and the top bit clear
    `FPI_ASSERT_IMP(a_valid_tag, clk, rst_n, out_good, m_axis_tdata[63:62] == 2'b01)
    // opening a text always costs length rounds before the next transfer
    `FPI_ASSERT_NXT(a_open_busy, clk, rst_n, in_xfer && status.opens, !s_axis_tready)

endmodule
